@@ rtl/core/olse_pkg.sv @@
package olse_pkg;

    // Fixed field widths of the request and response
    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 64;
    localparam int OCNT_W   = 7;
    localparam int S_DATA_W = 72;   // position + value, padded to whole bytes
    localparam int M_DATA_W = 72;   // ok + read value + count

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND   = 3'd0,
        KIND_INSERT   = 3'd1,
        KIND_ERASE    = 3'd2,
        KIND_DELETE   = 3'd3,
        KIND_GET      = 3'd4,
        KIND_SET      = 3'd5,
        KIND_CONTAINS = 3'd6,
        KIND_SIZE     = 3'd7
    } t_kind;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_SET    = 3'd4,
        CMD_MATCH  = 3'd5,
        CMD_SCAN   = 3'd6,
        CMD_REMOVE = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_EXEC   = 3'd1,
        ST_SCAN   = 3'd2,
        ST_FINISH = 3'd3,
        ST_EMIT   = 3'd4
    } t_state;

endpackage

@@ rtl/core/olse_cell.sv @@
module olse_cell #(
    parameter int DEPTH = 64,
    parameter int INDEX = 0
) (
    input  logic                              i_clk,
    input  olse_pkg::t_cell_ctl               i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]        i_count,
    input  logic [olse_pkg::VAL_W-1:0]        i_value,
    input  logic [olse_pkg::VAL_W-1:0]        i_left_entry,
    input  logic [olse_pkg::VAL_W-1:0]        i_right_entry,
    input  logic                              i_left_seen,
    output logic [olse_pkg::VAL_W-1:0]        o_entry,
    output logic                              o_seen
);
    import olse_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (POS_W > CW) ? POS_W : CW;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [VAL_W-1:0] r_entry, n_entry;
    logic             r_hit, n_hit;
    logic             r_seen, n_seen;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;

    assign w_pos = CMP_W'(i_ctl.pos);
    assign w_cnt = CMP_W'(i_count);

    always_comb begin
        n_entry = r_entry;
        n_hit   = r_hit;
        n_seen  = r_seen;
        unique case (i_ctl.cmd)
            CMD_APPEND: begin
                if (MY_IDX == w_cnt) n_entry = i_value;
            end
            CMD_INSERT: begin
                if (MY_IDX == w_pos) n_entry = i_value;
                else if (MY_IDX > w_pos) n_entry = i_left_entry;
            end
            CMD_ERASE: begin
                if (MY_IDX >= w_pos) n_entry = i_right_entry;
            end
            CMD_SET: begin
                if (MY_IDX == w_pos) n_entry = i_value;
            end
            CMD_MATCH: begin
                n_hit  = (MY_IDX < w_cnt) && (r_entry == i_value);
                n_seen = 1'b0;
            end
            CMD_SCAN: begin
                // prefix OR of hits ripples one cell per cycle
                n_seen = i_left_seen | r_hit;
            end
            CMD_REMOVE: begin
                if (r_seen) n_entry = i_right_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_hit   <= n_hit;
        r_seen  <= n_seen;
    end

    assign o_entry = r_entry;
    assign o_seen  = r_seen;

endmodule

@@ rtl/core/ordered_list_shift_engine.sv @@
// Ordered list of up to DEPTH 64-bit entries kept in a chain of cells, one
// entry per cell. Each request on the slave side is one list operation
// (tuser = kind: append, insert, erase, delete value, get, set, contains,
// size) and gives exactly one response with ok, read value and the entry
// count after the operation. Requests are handled one at a time. Append,
// insert, erase, get, set and size go from accept through an execute step and
// a load step into the response register, and the next request is taken once
// the engine is back in idle. Delete and contains take more steps: every
// cell compares its entry at once, then a found flag ripples down the chain
// one cell per cycle, a finish step shifts the tail down for a delete, and a
// last step loads the response. The response register lets a new request in
// while the previous response is still waiting for the master side; the load
// step stalls for as long as that previous response is not taken. Entries are
// not cleared at reset; only positions below the count are ever read.
module ordered_list_shift_engine #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side request
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [olse_pkg::S_DATA_W-1:0]     i_s_tdata,   // [5:0] position, [69:6] item_value
    input  logic [olse_pkg::KIND_W-1:0]       i_s_tuser,   // [2:0] kind
    // master side response
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [olse_pkg::M_DATA_W-1:0]     o_m_tdata    // [0] ok, [64:1] read_value,
                                                           // [71:65] entry_count
);
    import olse_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);
    localparam int CMP_W = (POS_W > CW) ? POS_W : CW;

    // control state
    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_m_valid, n_m_valid;

    // request and result payload
    t_kind                 r_kind, n_kind;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [VAL_W-1:0]      r_val, n_val;
    logic                  r_ok, n_ok;
    logic [VAL_W-1:0]      r_rd, n_rd;
    logic [IW-1:0]         r_scan, n_scan;
    logic [M_DATA_W-1:0]   r_m_data, n_m_data;

    t_cell_ctl             w_ctl;
    logic [VAL_W-1:0]      w_entry [DEPTH];
    logic [DEPTH-1:0]      w_seen;
    logic                  w_accept;
    logic                  w_not_full;
    logic [CMP_W-1:0]      w_pos_x;
    logic [CMP_W-1:0]      w_cnt_x;
    logic [IW-1:0]         w_get_idx;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_not_full = (r_count < CW'(DEPTH));
    assign w_pos_x    = CMP_W'(r_pos);
    assign w_cnt_x    = CMP_W'(r_count);
    assign w_get_idx  = w_pos_x[IW-1:0];

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        logic             w_left_seen;
        if (g == 0) begin : g_first
            assign w_left      = '0;
            assign w_left_seen = 1'b0;
        end else begin : g_mid
            assign w_left      = w_entry[g-1];
            assign w_left_seen = w_seen[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end
        olse_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_count       (r_count),
            .i_value       (r_val),
            .i_left_entry  (w_left),
            .i_right_entry (w_right),
            .i_left_seen   (w_left_seen),
            .o_entry       (w_entry[g]),
            .o_seen        (w_seen[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_ok     <= n_ok;
        r_rd     <= n_rd;
        r_scan   <= n_scan;
        r_m_data <= n_m_data;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_kind    = r_kind;
        n_pos     = r_pos;
        n_val     = r_val;
        n_ok      = r_ok;
        n_rd      = r_rd;
        n_scan    = r_scan;
        n_m_data  = r_m_data;
        n_m_valid = r_m_valid && !i_m_tready;
        w_ctl.cmd = CMD_HOLD;
        w_ctl.pos = r_pos;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_kind  = t_kind'(i_s_tuser);
                    n_pos   = i_s_tdata[POS_W-1:0];
                    n_val   = i_s_tdata[POS_W +: VAL_W];
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_ok    = 1'b0;
                n_rd    = '0;
                n_state = ST_EMIT;
                case (r_kind) inside
                    KIND_APPEND: begin
                        if (w_not_full) begin
                            w_ctl.cmd = CMD_APPEND;
                            n_count   = r_count + CW'(1);
                            n_ok      = 1'b1;
                        end
                    end
                    KIND_INSERT: begin
                        // position equal to the count lands at the end
                        if (w_not_full && (w_pos_x <= w_cnt_x)) begin
                            w_ctl.cmd = CMD_INSERT;
                            n_count   = r_count + CW'(1);
                            n_ok      = 1'b1;
                        end
                    end
                    KIND_ERASE: begin
                        if (w_pos_x < w_cnt_x) begin
                            w_ctl.cmd = CMD_ERASE;
                            n_count   = r_count - CW'(1);
                            n_ok      = 1'b1;
                        end
                    end
                    KIND_GET: begin
                        if (w_pos_x < w_cnt_x) begin
                            n_rd = w_entry[w_get_idx];
                            n_ok = 1'b1;
                        end
                    end
                    KIND_SET: begin
                        if (w_pos_x < w_cnt_x) begin
                            w_ctl.cmd = CMD_SET;
                            n_ok      = 1'b1;
                        end
                    end
                    KIND_DELETE, KIND_CONTAINS: begin
                        // compare in every cell, then ripple the found flag
                        w_ctl.cmd = CMD_MATCH;
                        n_scan    = '0;
                        n_state   = ST_SCAN;
                    end
                    default: begin
                        n_ok = 1'b1;   // size
                    end
                endcase
            end
            ST_SCAN: begin
                w_ctl.cmd = CMD_SCAN;
                if (r_scan == IW'(DEPTH - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_scan = r_scan + IW'(1);
                end
            end
            ST_FINISH: begin
                // last cell's flag is the OR of all hits
                n_ok    = w_seen[DEPTH-1];
                n_state = ST_EMIT;
                if ((r_kind == KIND_DELETE) && w_seen[DEPTH-1]) begin
                    w_ctl.cmd = CMD_REMOVE;
                    n_count   = r_count - CW'(1);
                end
            end
            ST_EMIT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {OCNT_W'(r_count), r_rd, r_ok};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // the count never runs past the chain length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // only the execute and finish steps may change the count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EXEC && r_state != ST_FINISH) |=> $stable(r_count))
        else $error("count changed outside an update step");

    // an accepted request blocks the slave side until its response is queued
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("second request taken while one is in flight");

endmodule

@@ verif/ordered_list_shift_engine_tb.sv @@
`timescale 1ns / 1ps

module ordered_list_shift_engine_tb;
    import olse_pkg::*;

    localparam int DEPTH = 64;
    // delete and contains walk the whole chain, so this covers the slowest request
    localparam int DRAIN_CYCLES = DEPTH + 16;

    // packed from the top bit down, so ok sits in bit 0 as on tdata
    typedef struct packed {
        logic [OCNT_W-1:0] entry_count;
        logic [VAL_W-1:0]  read_value;
        logic              ok;
    } list_resp_t;

    // DUT ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;   // [5:0] position, [69:6] item_value
    logic [KIND_W-1:0]   i_s_tuser = '0;   // [2:0] kind
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;        // [0] ok, [64:1] read_value, [71:65] entry_count

    // Shadow copy of the list: index 0 is the head
    logic [VAL_W-1:0] list_shadow[$];
    // Responses still owed by the DUT, oldest first
    list_resp_t       owed_resp_q[$];
    list_resp_t       want_resp;
    list_resp_t       got_resp;

    int fail_count    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_left = 0;   // cycles the receiver still refuses responses

    ordered_list_shift_engine #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one list request to the shadow list and returns the response it owes.
    function automatic list_resp_t apply_list_op(input t_kind kind,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] value);
        list_resp_t resp;
        int hit;
        resp = '0;
        hit  = -1;
        case (kind) inside
            KIND_APPEND: begin
                if (list_shadow.size() < DEPTH) begin
                    list_shadow.push_back(value);
                    resp.ok = 1'b1;
                end
            end
            KIND_INSERT: begin
                // position equal to the count behaves as an append
                if (list_shadow.size() < DEPTH && pos <= list_shadow.size()) begin
                    list_shadow.insert(pos, value);
                    resp.ok = 1'b1;
                end
            end
            KIND_ERASE: begin
                if (pos < list_shadow.size()) begin
                    list_shadow.delete(pos);
                    resp.ok = 1'b1;
                end
            end
            KIND_DELETE, KIND_CONTAINS: begin
                // first match from the head wins
                foreach (list_shadow[i])
                    if (hit < 0 && list_shadow[i] == value)
                        hit = i;
                if (hit >= 0) begin
                    resp.ok = 1'b1;
                    if (kind == KIND_DELETE)
                        list_shadow.delete(hit);
                end
            end
            KIND_GET: begin
                if (pos < list_shadow.size()) begin
                    resp.read_value = list_shadow[pos];
                    resp.ok = 1'b1;
                end
            end
            KIND_SET: begin
                if (pos < list_shadow.size()) begin
                    list_shadow[pos] = value;
                    resp.ok = 1'b1;
                end
            end
            default: resp.ok = 1'b1;   // size
        endcase
        resp.entry_count = OCNT_W'(list_shadow.size());
        return resp;
    endfunction

    // Offers one request, holds it until accepted, then records the owed response.
    // tvalid stays high into the next request when no gap is drawn.
    task automatic send_request(input t_kind kind, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {{(S_DATA_W - POS_W - VAL_W){1'b0}}, value, pos};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        owed_resp_q.push_back(apply_list_op(kind, pos, value));
    endtask

    // Response side: check on each accepted response, then draw tready for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_resp = o_m_tdata[OCNT_W+VAL_W:0];
            if (owed_resp_q.size() == 0) begin
                $error("response with none outstanding: tdata %h", o_m_tdata);
                fail_count++;
            end else begin
                want_resp = owed_resp_q.pop_front();
                if (got_resp.ok !== want_resp.ok) begin
                    $error("ok: expected %0d, actual %0d", want_resp.ok, got_resp.ok);
                    fail_count++;
                end
                if (got_resp.read_value !== want_resp.read_value) begin
                    $error("read_value: expected %h, actual %h",
                           want_resp.read_value, got_resp.read_value);
                    fail_count++;
                end
                if (got_resp.entry_count !== want_resp.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           want_resp.entry_count, got_resp.entry_count);
                    fail_count++;
                end
            end
        end
        // long hold-off first, then the random stall rate
        if (hold_off_left > 0) begin
            i_m_tready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Empty-list failures, edge positions, duplicates and extreme values.
    task automatic test_directed();
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_request(KIND_SIZE,     6'd0,  64'd0);
        send_request(KIND_GET,      6'd0,  64'd0);
        send_request(KIND_ERASE,    6'd0,  64'd0);
        send_request(KIND_SET,      6'd0,  64'd7);
        send_request(KIND_DELETE,   6'd0,  64'd5);
        send_request(KIND_CONTAINS, 6'd63, 64'd5);
        send_request(KIND_INSERT,   6'd1,  64'd9);              // past the end
        send_request(KIND_INSERT,   6'd0,  {VAL_W{1'b1}});
        send_request(KIND_APPEND,   6'd63, 64'd0);
        send_request(KIND_APPEND,   6'd0,  64'd5);
        send_request(KIND_INSERT,   6'd3,  64'd5);              // at the count, duplicate
        send_request(KIND_INSERT,   6'd1,  64'hA5A5_5A5A_F00F_0FF0);
        send_request(KIND_GET,      6'd4,  64'd0);
        send_request(KIND_GET,      6'd63, 64'd0);
        send_request(KIND_SET,      6'd0,  64'd1);
        send_request(KIND_CONTAINS, 6'd0,  64'd5);
        send_request(KIND_DELETE,   6'd0,  64'd5);              // removes the first copy only
        send_request(KIND_GET,      6'd3,  64'd0);
        send_request(KIND_CONTAINS, 6'd0,  {VAL_W{1'b1}});
        send_request(KIND_ERASE,    6'd0,  64'd0);
        send_request(KIND_ERASE,    6'd2,  64'd0);              // tail entry
        send_request(KIND_INSERT,   6'd63, 64'd3);
        send_request(KIND_SIZE,     6'd17, {VAL_W{1'b1}});
    endtask

    // Receiver holds off for a long stretch while appends keep coming, so the
    // response path backs up and tready drops; the list also reaches full.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 10;
        hold_off_left = 300;
        for (int i = 0; i < DEPTH + 4; i++)
            send_request(KIND_APPEND, 6'($urandom_range(0, 63)), {$urandom, $urandom});
        send_request(KIND_INSERT,   6'd0,  64'd1);              // full list
        send_request(KIND_GET,      6'd63, 64'd0);
        send_request(KIND_GET,      6'd0,  64'd0);
        send_request(KIND_CONTAINS, 6'd0,  list_shadow[DEPTH-1]);
        send_request(KIND_ERASE,    6'd63, 64'd0);
        send_request(KIND_INSERT,   6'd63, 64'd2);              // refill at the last slot
        send_request(KIND_SIZE,     6'd0,  64'd0);
    endtask

    // Picks a value: usually one already in the list when a match is wanted,
    // otherwise a small value (for duplicates) or a wide random one.
    function automatic logic [VAL_W-1:0] pick_value(input bit want_match);
        if (list_shadow.size() != 0 && $urandom_range(0, 99) < (want_match ? 70 : 10))
            return list_shadow[$urandom_range(0, list_shadow.size() - 1)];
        if ($urandom_range(0, 99) < 20)
            return 64'($urandom_range(0, 7));
        return {$urandom, $urandom};
    endfunction

    // Random requests in segments that lean toward growing, shrinking or neither,
    // so the list swings between empty and full.
    task automatic test_random(input int n_items, input int snd_pct, input int rcv_pct);
        int               lean;
        int               top;
        t_kind            kind;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
        lean = 0;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                lean = $urandom_range(0, 2);
            if (lean == 0 && $urandom_range(0, 99) < 60)
                kind = $urandom_range(0, 1) ? KIND_INSERT : KIND_APPEND;
            else if (lean == 1 && $urandom_range(0, 99) < 60)
                kind = $urandom_range(0, 1) ? KIND_DELETE : KIND_ERASE;
            else
                kind = t_kind'($urandom_range(0, 7));
            // mostly in range, sometimes anywhere
            top = (list_shadow.size() > 63) ? 63 : list_shadow.size();
            if ($urandom_range(0, 99) < 80)
                pos = 6'($urandom_range(0, top));
            else
                pos = 6'($urandom_range(0, 63));
            value = pick_value(kind == KIND_DELETE || kind == KIND_CONTAINS);
            send_request(kind, pos, value);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(340, 36, 55);
        test_backpressure();
        test_random(340, 55, 36);
        test_random(320, 0, 0);

        i_s_tvalid <= 1'b0;
        while (owed_resp_q.size() != 0)
            @(posedge i_clk);
        // catch any stray response after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("ordered_list_shift_engine_tb passed");
        else
            $display("ordered_list_shift_engine_tb failed");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial begin
        #2000000;
        $display("ordered_list_shift_engine_tb failed");
        $finish;
    end

endmodule

@@ ordered_list_shift_engine.f @@
rtl/core/olse_pkg.sv
rtl/core/olse_cell.sv
rtl/core/ordered_list_shift_engine.sv
verif/ordered_list_shift_engine_tb.sv
